// ----- rtl/scp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_pkg
// shared constants, pair codes and the queue status type for the overlap test
// ----------------------------------------------------------------------------
package scp_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [1:0] KIND_SS  = 2'd0;
    localparam logic [1:0] KIND_SC  = 2'd1;
    localparam logic [1:0] KIND_CC  = 2'd2;
    localparam logic [1:0] KIND_BAD = 2'd3;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

endpackage

// ----- rtl/sphere_capsule_overlap_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_capsule_overlap_test
// sphere against sphere or capsule overlap test, exact integer compare
// ----------------------------------------------------------------------------
//  channel   handshake         payload
//  query     push / full       i_req_type, sphere, head, tail, radii
//  result    pop / empty       o_hit, o_bad_pair
//
//  one query per cycle sustained while results are popped; a query passes the
//  queue entry, then five back stages ending in the result register
//  synchronous active-low reset empties the queue and the back pipeline
//  a held result stalls the back stages; the front queue keeps taking
//  queries until its four entries are full
// ----------------------------------------------------------------------------
module sphere_capsule_overlap_test #(
    parameter int COORD_BITS = scp_pkg::COORD_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [1:0]             i_req_type,
    input  logic [COORD_BITS-1:0]  i_sphere_x,
    input  logic [COORD_BITS-1:0]  i_sphere_y,
    input  logic [COORD_BITS-1:0]  i_sphere_z,
    input  logic [COORD_BITS-1:0]  i_sphere_radius,
    input  logic [COORD_BITS-1:0]  i_head_x,
    input  logic [COORD_BITS-1:0]  i_head_y,
    input  logic [COORD_BITS-1:0]  i_head_z,
    input  logic [COORD_BITS-1:0]  i_tail_x,
    input  logic [COORD_BITS-1:0]  i_tail_y,
    input  logic [COORD_BITS-1:0]  i_tail_z,
    input  logic [COORD_BITS-1:0]  i_other_radius,
    output logic                   empty,
    input  logic                   pop,
    output logic                   o_hit,
    output logic                   o_bad_pair
);
    import scp_pkg::*;

    localparam int W = 10*COORD_BITS + 12;

    logic [W-1:0]  w_fdata, w_qdata;
    t_queue_stat   w_stat;
    logic          w_take;

    scp_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_req_type      (i_req_type),
        .i_sphere_x      (i_sphere_x),
        .i_sphere_y      (i_sphere_y),
        .i_sphere_z      (i_sphere_z),
        .i_sphere_radius (i_sphere_radius),
        .i_head_x        (i_head_x),
        .i_head_y        (i_head_y),
        .i_head_z        (i_head_z),
        .i_tail_x        (i_tail_x),
        .i_tail_y        (i_tail_y),
        .i_tail_z        (i_tail_z),
        .i_other_radius  (i_other_radius),
        .o_data          (w_fdata)
    );

    scp_queue #(.WIDTH(W), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_data  (w_fdata),
        .i_rd    (w_take),
        .o_data  (w_qdata),
        .o_stat  (w_stat)
    );

    assign full = w_stat.full;

    scp_back #(.COORD_BITS(COORD_BITS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_stat     (w_stat),
        .i_data     (w_qdata),
        .o_take     (w_take),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_hit      (o_hit),
        .o_bad_pair (o_bad_pair)
    );

endmodule

// ----- rtl/scp_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_front
// forms the point differences and radius sum of a query and packs them
// ----------------------------------------------------------------------------
module scp_front #(
    parameter int COORD_BITS = scp_pkg::COORD_BITS_DEF
) (
    input  logic [1:0]                       i_req_type,
    input  logic [COORD_BITS-1:0]            i_sphere_x,
    input  logic [COORD_BITS-1:0]            i_sphere_y,
    input  logic [COORD_BITS-1:0]            i_sphere_z,
    input  logic [COORD_BITS-1:0]            i_sphere_radius,
    input  logic [COORD_BITS-1:0]            i_head_x,
    input  logic [COORD_BITS-1:0]            i_head_y,
    input  logic [COORD_BITS-1:0]            i_head_z,
    input  logic [COORD_BITS-1:0]            i_tail_x,
    input  logic [COORD_BITS-1:0]            i_tail_y,
    input  logic [COORD_BITS-1:0]            i_tail_z,
    input  logic [COORD_BITS-1:0]            i_other_radius,
    output logic [10*COORD_BITS+12-1:0]      o_data
);
    import scp_pkg::*;

    localparam int D = COORD_BITS + 1;

    logic [D-1:0] w_p [3];
    logic [D-1:0] w_h [3];
    logic [D-1:0] w_t [3];
    logic [D-1:0] w_hp [3];
    logic [D-1:0] w_tp [3];
    logic [D-1:0] w_ht [3];
    logic [D-1:0] w_rsum;

    always_comb begin
        w_p[0] = {i_sphere_x[COORD_BITS-1], i_sphere_x};
        w_p[1] = {i_sphere_y[COORD_BITS-1], i_sphere_y};
        w_p[2] = {i_sphere_z[COORD_BITS-1], i_sphere_z};
        w_h[0] = {i_head_x[COORD_BITS-1], i_head_x};
        w_h[1] = {i_head_y[COORD_BITS-1], i_head_y};
        w_h[2] = {i_head_z[COORD_BITS-1], i_head_z};
        w_t[0] = {i_tail_x[COORD_BITS-1], i_tail_x};
        w_t[1] = {i_tail_y[COORD_BITS-1], i_tail_y};
        w_t[2] = {i_tail_z[COORD_BITS-1], i_tail_z};
        for (int k = 0; k < 3; k++) begin
            w_hp[k] = w_p[k] - w_h[k];
            w_tp[k] = w_p[k] - w_t[k];
            w_ht[k] = w_t[k] - w_h[k];
        end
        w_rsum = {1'b0, i_sphere_radius} + {1'b0, i_other_radius};
        o_data = {i_req_type, w_rsum,
                  w_ht[2], w_ht[1], w_ht[0],
                  w_tp[2], w_tp[1], w_tp[0],
                  w_hp[2], w_hp[1], w_hp[0]};
    end

endmodule

// ----- rtl/scp_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_queue
// short queue between front and back so each side stalls on its own
// ----------------------------------------------------------------------------
module scp_queue #(
    parameter int WIDTH = 16,
    parameter int DEPTH = scp_pkg::QUEUE_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_wr,
    input  logic [WIDTH-1:0]          i_data,
    input  logic                      i_rd,
    output logic [WIDTH-1:0]          o_data,
    output scp_pkg::t_queue_stat      o_stat
);
    import scp_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, n_wptr;
    logic [AW-1:0]    r_rptr, n_rptr;
    logic [AW:0]      r_cnt, n_cnt;
    logic             w_wr, w_rd;

    assign o_stat.full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign w_wr = i_wr && !o_stat.full;
    assign w_rd = i_rd && !o_stat.empty;
    assign o_data = r_mem[r_rptr];

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (w_wr) begin
            n_wptr = (r_wptr == AW'(DEPTH-1)) ? '0 : r_wptr + 1'b1;
        end
        if (w_rd) begin
            n_rptr = (r_rptr == AW'(DEPTH-1)) ? '0 : r_rptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// ----- rtl/scp_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_mul
// two-stage unsigned multiplier built from four half-width partial products
// ----------------------------------------------------------------------------
module scp_mul #(
    parameter int WIDTH = 36
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [WIDTH-1:0]     i_a,
    input  logic [WIDTH-1:0]     i_b,
    output logic [2*WIDTH-1:0]   o_p
);
    localparam int H = (WIDTH + 1) / 2;

    logic [2*H-1:0] w_a, w_b;
    logic [2*H-1:0] r_p00, r_p01, r_p10, r_p11;
    logic [4*H-1:0] w_sum;
    logic [2*WIDTH-1:0] r_p;

    assign w_a = (2*H)'(i_a);
    assign w_b = (2*H)'(i_b);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p00 <= w_a[H-1:0]   * w_b[H-1:0];
            r_p01 <= w_a[H-1:0]   * w_b[2*H-1:H];
            r_p10 <= w_a[2*H-1:H] * w_b[H-1:0];
            r_p11 <= w_a[2*H-1:H] * w_b[2*H-1:H];
        end
    end

    assign w_sum = {r_p11, r_p00}
                 + {{H{1'b0}}, r_p01, {H{1'b0}}}
                 + {{H{1'b0}}, r_p10, {H{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= w_sum[2*WIDTH-1:0];
        end
    end

    assign o_p = r_p;

endmodule

// ----- rtl/scp_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_back
// five-stage distance and compare pipeline with a result register at the end
// ----------------------------------------------------------------------------
module scp_back #(
    parameter int COORD_BITS = scp_pkg::COORD_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  scp_pkg::t_queue_stat             i_stat,
    input  logic [10*COORD_BITS+12-1:0]      i_data,
    output logic                             o_take,
    input  logic                             i_pop,
    output logic                             o_empty,
    output logic                             o_hit,
    output logic                             o_bad_pair
);
    import scp_pkg::*;

    localparam int D = COORD_BITS + 1;
    localparam int R = COORD_BITS + 1;
    localparam int P = 2*COORD_BITS + 4;
    localparam int X = P - 2*D;

    logic signed [D-1:0]   w_hp [3];
    logic signed [D-1:0]   w_tp [3];
    logic signed [D-1:0]   w_ht [3];
    logic [R-1:0]          w_rsum;
    logic [1:0]            w_kind;
    logic                  w_adv;

    logic [4:0]            r_v;
    logic [1:0]            r_kind [4];

    logic signed [2*D-1:0] r_phh [3];
    logic signed [2*D-1:0] r_pe  [3];
    logic signed [2*D-1:0] r_pf  [3];
    logic signed [2*D-1:0] r_ptt [3];
    logic [2*R-1:0]        r_r2a;

    logic signed [P-1:0]   r_hh, r_e, r_f, r_tt, r_r2;
    logic [P-1:0]          w_emag;

    logic                  r_hh_ok [2];
    logic                  r_tt_ok [2];
    logic                  r_e_le0 [2];
    logic                  r_f_le_e [2];

    logic [2*P-1:0]        w_hhf, w_ee, w_r2f;
    logic [2*P:0]          w_rhs;
    logic                  w_mid_ok;
    logic                  r_hit, r_bad;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_hp[k] = i_data[k*D +: D];
            w_tp[k] = i_data[(3+k)*D +: D];
            w_ht[k] = i_data[(6+k)*D +: D];
        end
        w_rsum = i_data[9*D +: R];
        w_kind = i_data[9*D+R +: 2];
    end

    assign w_adv   = !r_v[4] || i_pop;
    assign o_take  = w_adv && !i_stat.empty;
    assign o_empty = !r_v[4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_adv) begin
            r_v <= {r_v[3:0], !i_stat.empty};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < 3; k++) begin
                r_phh[k] <= w_hp[k] * w_hp[k];
                r_pe[k]  <= w_hp[k] * w_ht[k];
                r_pf[k]  <= w_ht[k] * w_ht[k];
                r_ptt[k] <= w_tp[k] * w_tp[k];
            end
            r_r2a    <= w_rsum * w_rsum;
            r_kind[0] <= w_kind;

            r_hh <= {{X{r_phh[0][2*D-1]}}, r_phh[0]} + {{X{r_phh[1][2*D-1]}}, r_phh[1]}
                  + {{X{r_phh[2][2*D-1]}}, r_phh[2]};
            r_e  <= {{X{r_pe[0][2*D-1]}}, r_pe[0]} + {{X{r_pe[1][2*D-1]}}, r_pe[1]}
                  + {{X{r_pe[2][2*D-1]}}, r_pe[2]};
            r_f  <= {{X{r_pf[0][2*D-1]}}, r_pf[0]} + {{X{r_pf[1][2*D-1]}}, r_pf[1]}
                  + {{X{r_pf[2][2*D-1]}}, r_pf[2]};
            r_tt <= {{X{r_ptt[0][2*D-1]}}, r_ptt[0]} + {{X{r_ptt[1][2*D-1]}}, r_ptt[1]}
                  + {{X{r_ptt[2][2*D-1]}}, r_ptt[2]};
            r_r2 <= $signed({{(P-2*R){1'b0}}, r_r2a});
            r_kind[1] <= r_kind[0];

            r_hh_ok[0]  <= (r_hh <= r_r2);
            r_tt_ok[0]  <= (r_tt <= r_r2);
            r_e_le0[0]  <= (r_e <= $signed({P{1'b0}}));
            r_f_le_e[0] <= (r_f <= r_e);
            r_kind[2]   <= r_kind[1];

            r_hh_ok[1]  <= r_hh_ok[0];
            r_tt_ok[1]  <= r_tt_ok[0];
            r_e_le0[1]  <= r_e_le0[0];
            r_f_le_e[1] <= r_f_le_e[0];
            r_kind[3]   <= r_kind[2];

            r_bad <= (r_kind[3] == KIND_BAD);
            unique case (r_kind[3])
                KIND_SS: r_hit <= r_hh_ok[1];
                KIND_SC: begin
                    if (r_e_le0[1]) begin
                        r_hit <= r_hh_ok[1];
                    end else if (r_f_le_e[1]) begin
                        r_hit <= r_tt_ok[1];
                    end else begin
                        r_hit <= w_mid_ok;
                    end
                end
                default: r_hit <= 1'b0;
            endcase
        end
    end

    assign w_emag = r_e[P-1] ? P'(-r_e) : P'(r_e);

    scp_mul #(.WIDTH(P)) u_mul_hhf (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_a   (P'(r_hh)),
        .i_b   (P'(r_f)),
        .o_p   (w_hhf)
    );

    scp_mul #(.WIDTH(P)) u_mul_ee (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_a   (w_emag),
        .i_b   (w_emag),
        .o_p   (w_ee)
    );

    scp_mul #(.WIDTH(P)) u_mul_r2f (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_a   (P'(r_r2)),
        .i_b   (P'(r_f)),
        .o_p   (w_r2f)
    );

    assign w_rhs    = {1'b0, w_r2f} + {1'b0, w_ee};
    assign w_mid_ok = ({1'b0, w_hhf} <= w_rhs);

    assign o_hit      = r_hit;
    assign o_bad_pair = r_bad;

endmodule

// ----- tb/sphere_capsule_overlap_test_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_capsule_overlap_test_tb
// drives overlap queries through the push side and pops hit flags, with a
// local exact-integer predictor and an in-order scoreboard of expected flags
// ----------------------------------------------------------------------------
module sphere_capsule_overlap_test_tb;
    import scp_pkg::*;

    typedef struct {
        logic [1:0]  kind;
        logic [15:0] sp [3];
        logic [15:0] hd [3];
        logic [15:0] tl [3];
        logic [15:0] r_sph;
        logic [15:0] r_oth;
    } t_query;

    typedef struct {
        logic hit;
        logic bad_pair;
    } t_flags;

    class overlap_board;
        t_flags pending [$];
        int     errors = 0;

        function t_flags predict(t_query q);
            t_flags f;
            logic signed [19:0]  hp [3];
            logic signed [19:0]  tp [3];
            logic signed [19:0]  ht [3];
            logic signed [127:0] r2, e, g, dhh, dtt;
            dhh = 0;
            dtt = 0;
            e = 0;
            g = 0;
            r2 = ({1'b0, q.r_sph} + {1'b0, q.r_oth}) * ({1'b0, q.r_sph} + {1'b0, q.r_oth});
            for (int k = 0; k < 3; k++) begin
                hp[k] = $signed(q.sp[k]) - $signed(q.hd[k]);
                tp[k] = $signed(q.sp[k]) - $signed(q.tl[k]);
                ht[k] = $signed(q.tl[k]) - $signed(q.hd[k]);
                dhh += hp[k] * hp[k];
                dtt += tp[k] * tp[k];
                e   += hp[k] * ht[k];
                g   += ht[k] * ht[k];
            end
            f.hit = 1'b0;
            if (q.kind == KIND_SS)
                f.hit = dhh <= r2;
            else if (q.kind == KIND_SC) begin
                if (e <= 0) f.hit = dhh <= r2;
                else if (g <= e) f.hit = dtt <= r2;
                else f.hit = (dhh * g - e * e) <= r2 * g;
            end
            f.bad_pair = q.kind == KIND_BAD;
            return f;
        endfunction

        function void note_query(t_query q);
            pending.push_back(predict(q));
        endfunction

        function void check_flags(logic hit, logic bad_pair);
            t_flags x;
            if (pending.size() == 0) begin
                $error("result with no query waiting");
                errors++;
                return;
            end
            x = pending.pop_front();
            if (hit !== x.hit) begin
                $error("hit expected %0b actual %0b", x.hit, hit);
                errors++;
            end
            if (bad_pair !== x.bad_pair) begin
                $error("bad_pair expected %0b actual %0b", x.bad_pair, bad_pair);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        pop = 1'b0;
    logic        full, empty, o_hit, o_bad_pair;
    logic [1:0]  i_req_type = '0;
    logic [15:0] i_sphere_x = '0, i_sphere_y = '0, i_sphere_z = '0, i_sphere_radius = '0;
    logic [15:0] i_head_x = '0, i_head_y = '0, i_head_z = '0;
    logic [15:0] i_tail_x = '0, i_tail_y = '0, i_tail_z = '0, i_other_radius = '0;

    int send_idle = 0;
    int recv_stall = 0;
    overlap_board board = new();

    sphere_capsule_overlap_test u_top (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // receive side: sample at rising edge, choose pop at falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) board.check_flags(o_hit, o_bad_pair);
    end

    always @(negedge i_clk) begin
        pop <= ($urandom_range(99) >= recv_stall);
    end

    function automatic logic [15:0] rnd_coord(int spread);
        case ($urandom_range(5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($urandom);
            default: return 16'($signed(16'($urandom_range(2 * spread))) - spread);
        endcase
    endfunction

    function automatic t_query rnd_query();
        t_query q;
        int spread;
        spread = ($urandom_range(3) == 0) ? 32767 : 2000;
        q.kind = ($urandom_range(9) < 6) ? KIND_SC : 2'($urandom);
        for (int k = 0; k < 3; k++) begin
            q.sp[k] = rnd_coord(spread);
            q.hd[k] = rnd_coord(spread);
            q.tl[k] = ($urandom_range(15) == 0) ? q.hd[k] : rnd_coord(spread);
        end
        q.r_sph = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(1500));
        q.r_oth = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(1500));
        return q;
    endfunction

    task automatic send_query(t_query q);
        while ($urandom_range(99) < send_idle) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_req_type <= q.kind;
        {i_sphere_x, i_sphere_y, i_sphere_z} <= {q.sp[0], q.sp[1], q.sp[2]};
        {i_head_x, i_head_y, i_head_z} <= {q.hd[0], q.hd[1], q.hd[2]};
        {i_tail_x, i_tail_y, i_tail_z} <= {q.tl[0], q.tl[1], q.tl[2]};
        i_sphere_radius <= q.r_sph;
        i_other_radius <= q.r_oth;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        board.note_query(q);
        @(negedge i_clk);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
    endtask

    function automatic t_query make_query(logic [1:0] kind, logic [15:0] s, logic [15:0] h,
                                          logic [15:0] t, logic [15:0] rs, logic [15:0] ro);
        t_query q;
        q.kind = kind;
        for (int k = 0; k < 3; k++) begin
            q.sp[k] = s;
            q.hd[k] = h;
            q.tl[k] = t;
        end
        q.r_sph = rs;
        q.r_oth = ro;
        return q;
    endfunction

    initial begin
        t_query q;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // extremes, every pair kind, touching, degenerate segment, clamp ends
        send_query(make_query(KIND_SS, 16'h7fff, 16'h8000, 16'h0, 16'hffff, 16'hffff));
        send_query(make_query(KIND_SS, 16'h8000, 16'h7fff, 16'h0, 16'h0, 16'h0));
        send_query(make_query(KIND_SS, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
        send_query(make_query(KIND_SC, 16'h7fff, 16'h8000, 16'h8000, 16'hffff, 16'hffff));
        send_query(make_query(KIND_SC, 16'd0, 16'd100, 16'd100, 16'd0, 16'd0));
        send_query(make_query(KIND_SC, 16'd0, 16'd100, 16'd100, 16'd173, 16'd0));
        send_query(make_query(KIND_SC, 16'd500, 16'd0, 16'd100, 16'd10, 16'd10));
        send_query(make_query(KIND_SC, 16'hffce, 16'd0, 16'd100, 16'd10, 16'd10));
        send_query(make_query(KIND_SC, 16'd50, 16'hff9c, 16'd100, 16'd1, 16'd1));
        send_query(make_query(KIND_CC, 16'd0, 16'd0, 16'd0, 16'hffff, 16'hffff));
        send_query(make_query(KIND_BAD, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
        q = make_query(KIND_SS, 16'd0, 16'd0, 16'd0, 16'd3, 16'd2);
        q.hd[0] = 16'd3;
        q.hd[1] = 16'd4;
        send_query(q);
        q = make_query(KIND_SC, 16'd0, 16'd0, 16'd0, 16'd4, 16'd0);
        q.sp[1] = 16'd5;
        q.hd[0] = 16'hff9c;
        q.tl[0] = 16'd100;
        send_query(q);
        drain();
        for (int ph = 0; ph < 4; ph++) begin
            send_idle  = (ph == 1 || ph == 3) ? ((ph == 3) ? 35 : 73) : 0;
            recv_stall = (ph == 2 || ph == 3) ? ((ph == 3) ? 35 : 73) : 0;
            for (int n = 0; n < 325; n++) begin
                send_query(rnd_query());
                if (n == 160 && ph == 0) drain();
            end
        end
        send_idle = 0;
        recv_stall = 0;
        drain();
        repeat (20) @(negedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #4000000;
        $display("simulation failed");
        $finish;
    end

endmodule
